// File: hdl/sskc_pkg.sv
// shared types and constants for the stereo soft-knee compressor
package sskc_pkg;

	localparam int SampleBits = 24;
	localparam int GainBits   = 16;
	localparam int DbBits     = 24;
	localparam int AddrBits   = 5;

	// register byte addresses
	localparam logic [AddrBits-1:0] AddrEnable       = 5'd0;
	localparam logic [AddrBits-1:0] AddrInputGain    = 5'd4;
	localparam logic [AddrBits-1:0] AddrOutputGain   = 5'd8;
	localparam logic [AddrBits-1:0] AddrThreshold    = 5'd12;
	localparam logic [AddrBits-1:0] AddrSlope        = 5'd16;
	localparam logic [AddrBits-1:0] AddrKnee         = 5'd20;
	localparam logic [AddrBits-1:0] AddrAlphaAttack  = 5'd24;
	localparam logic [AddrBits-1:0] AddrAlphaRelease = 5'd28;

	// level floor, round(1e-6 * 2^23)
	localparam logic [40:0] LevelFloor = 41'd8;
	localparam logic signed [23:0] DbPerLog2Q16 = 24'sd394566;
	localparam logic signed [23:0] Log2PerDbQ24 = 24'sd2786635;

	typedef struct packed {
		logic                        enable;
		logic [GainBits-1:0]         input_gain;
		logic [GainBits-1:0]         output_gain;
		logic signed [14:0]          threshold_db;
		logic signed [15:0]          slope;
		logic [12:0]                 knee_db;
		logic [15:0]                 alpha_attack;
		logic [15:0]                 alpha_release;
	} cfg_t;

	// datapath operation codes
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_GAIN_L,
		OP_GAIN_R,
		OP_LEVEL,
		OP_LOG_STEP,
		OP_DB,
		OP_CURVE,
		OP_KNEE_MUL,
		OP_DIV_STEP,
		OP_SMOOTH,
		OP_EXP,
		OP_POLY_STEP,
		OP_APPLY_L,
		OP_APPLY_R,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
		logic [1:0] sub;
	} cmd_t;

	typedef struct packed {
		logic knee_path;
		logic done_div;
	} sts_t;

endpackage

// File: hdl/sskc_regs.sv
// APB register file holding the compressor settings
module sskc_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sskc_pkg::AddrBits-1:0]       paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output sskc_pkg::cfg_t                      cfg
);

	sskc_pkg::cfg_t cfg_q;
	logic wr;

	assign wr = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= 1'b0;
			cfg_q.input_gain    <= 16'd4096;
			cfg_q.output_gain   <= 16'd4096;
			cfg_q.threshold_db  <= 15'sh6C00;
			cfg_q.slope         <= 16'shC000;
			cfg_q.knee_db       <= 13'd0;
			cfg_q.alpha_attack  <= 16'd65000;
			cfg_q.alpha_release <= 16'd65500;
		end else if (wr) begin
			case (paddr)
				sskc_pkg::AddrEnable:       cfg_q.enable        <= pwdata[0];
				sskc_pkg::AddrInputGain:    cfg_q.input_gain    <= pwdata[15:0];
				sskc_pkg::AddrOutputGain:   cfg_q.output_gain   <= pwdata[15:0];
				sskc_pkg::AddrThreshold:    cfg_q.threshold_db  <= pwdata[14:0];
				sskc_pkg::AddrSlope:        cfg_q.slope         <= pwdata[15:0];
				sskc_pkg::AddrKnee:         cfg_q.knee_db       <= pwdata[12:0];
				sskc_pkg::AddrAlphaAttack:  cfg_q.alpha_attack  <= pwdata[15:0];
				sskc_pkg::AddrAlphaRelease: cfg_q.alpha_release <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr)
			sskc_pkg::AddrEnable:       prdata = {31'd0, cfg_q.enable};
			sskc_pkg::AddrInputGain:    prdata = {16'd0, cfg_q.input_gain};
			sskc_pkg::AddrOutputGain:   prdata = {16'd0, cfg_q.output_gain};
			sskc_pkg::AddrThreshold:    prdata = {17'd0, cfg_q.threshold_db};
			sskc_pkg::AddrSlope:        prdata = {16'd0, cfg_q.slope};
			sskc_pkg::AddrKnee:         prdata = {19'd0, cfg_q.knee_db};
			sskc_pkg::AddrAlphaAttack:  prdata = {16'd0, cfg_q.alpha_attack};
			sskc_pkg::AddrAlphaRelease: prdata = {16'd0, cfg_q.alpha_release};
			default:                    prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/sskc_datapath.sv
// sequenced datapath: gain, log, static curve, smoothing, exp, output
module sskc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sskc_pkg::cfg_t                cfg,
	input  sskc_pkg::cmd_t                cmd,
	input  logic signed [23:0]            in_l,
	input  logic signed [23:0]            in_r,
	output sskc_pkg::sts_t                sts,
	output logic signed [23:0]            res_l,
	output logic signed [23:0]            res_r,
	output logic signed [23:0]            res_gr
);

	// working registers
	logic signed [23:0] xl_q, xr_q;
	logic signed [40:0] gl_q, gr_q;
	logic [5:0]         p_q;
	logic [31:0]        mant_q;
	logic [15:0]        frac_q;
	logic signed [23:0] db_q;
	logic signed [24:0] att_q;
	logic signed [23:0] s_q;
	logic [27:0]        num_q;
	logic [63:0]        rem_q;
	logic [63:0]        quo_q;
	logic [31:0]        den_q;
	logic [5:0]         divi_q;
	logic               neg_q;
	logic               knee_q;
	logic signed [23:0] e_q;
	logic [17:0]        poly_q;
	logic [15:0]        lin_q;
	logic signed [23:0] yl_q, yr_q;

	// combinational helpers
	logic signed [24:0] o_db;
	logic signed [25:0] twice;
	logic signed [25:0] kneew;
	logic signed [26:0] dsum;
	logic [16:0] slope_mag;
	logic [63:0] sq;
	logic [40:0] al, ar, mm;
	logic [5:0]  pp;
	logic signed [63:0] dbp;
	logic signed [63:0] smoothp;
	logic signed [63:0] smoothr;
	logic signed [63:0] ep;
	logic signed [23:0] en;
	logic [15:0] ef;
	logic signed [7:0] rr;
	logic [64:0] trial;
	logic signed [63:0] ogp;
	logic signed [63:0] ogr;
	logic signed [63:0] mulo;
	logic signed [63:0] t64;
	logic [15:0] alpha;
	logic signed [63:0] apl;

	always_comb begin
		al = gl_q[40] ? 41'(-gl_q) : gl_q;
		ar = gr_q[40] ? 41'(-gr_q) : gr_q;
		mm = (al > ar) ? al : ar;
		if (mm < sskc_pkg::LevelFloor)
			mm = sskc_pkg::LevelFloor;
		pp = 6'd0;
		for (int i = 1; i < 41; i++) begin
			if (mm[i])
				pp = 6'(i);
		end
		sq = 64'(mant_q) * 64'(mant_q);
		dbp = (64'(signed'({1'b0, p_q})) - 64'sd23) * 64'sd65536 + 64'(frac_q);
		o_db = 25'(db_q) - 25'(cfg.threshold_db);
		twice = {o_db, 1'b0};
		kneew = 26'(signed'({1'b0, cfg.knee_db}));
		dsum = 27'(twice) + 27'(kneew);
		slope_mag = cfg.slope[15] ? 17'(-17'(cfg.slope)) : 17'(cfg.slope);
		alpha = (att_q < 25'(s_q)) ? cfg.alpha_attack : cfg.alpha_release;
		smoothp = 64'(signed'({1'b0, alpha})) * 64'(s_q)
			+ (64'sd65536 - 64'(signed'({1'b0, alpha}))) * 64'(att_q) + 64'sd32768;
		smoothr = smoothp >>> 16;
		ep = 64'(s_q) * 64'(sskc_pkg::Log2PerDbQ24) + 64'sd32768;
		en = e_q >>> 16;
		ef = e_q[15:0];
		rr = 8'sd4 - 8'(en);
		trial = {rem_q, quo_q[63]} - {33'd0, den_q};
		t64 = 64'(poly_q) * 64'(ef);
		apl = (cmd.sub[0] ? 64'(gr_q) : 64'(gl_q)) * 64'(lin_q) + 64'sd2048;
		// output gain and saturation
		ogp = (cmd.sub[0] ? 64'(gr_q) : 64'(gl_q)) * 64'(signed'({1'b0, cfg.output_gain}))
			+ 64'sd2048;
		ogr = ogp >>> 12;
		if (ogr > 64'sd8388607)
			mulo = 64'sd8388607;
		else if (ogr < -64'sd8388608)
			mulo = -64'sd8388608;
		else
			mulo = ogr;
	end

	// sequenced datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q    <= 24'sd0;
			divi_q <= 6'd0;
		end else begin
			case (cmd.op)
				sskc_pkg::OP_LOAD: begin
					xl_q <= in_l;
					xr_q <= in_r;
				end
				sskc_pkg::OP_GAIN_L:
					gl_q <= 41'((64'(xl_q) * 64'(cfg.input_gain) + 64'sd2048) >>> 12);
				sskc_pkg::OP_GAIN_R:
					gr_q <= 41'((64'(xr_q) * 64'(cfg.input_gain) + 64'sd2048) >>> 12);
				sskc_pkg::OP_LEVEL: begin
					p_q    <= pp;
					mant_q <= (pp <= 6'd30) ? 32'(mm << (6'd30 - pp)) : 32'(mm >> (pp - 6'd30));
					frac_q <= 16'd0;
				end
				sskc_pkg::OP_LOG_STEP: begin
					if (sq[61]) begin
						mant_q <= 32'(sq >> 31);
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						mant_q <= 32'(sq >> 30);
						frac_q <= {frac_q[14:0], 1'b0};
					end
				end
				sskc_pkg::OP_DB:
					db_q <= 24'((dbp * 64'(sskc_pkg::DbPerLog2Q16) + 64'sd8388608) >>> 24);
				sskc_pkg::OP_CURVE: begin
					if ((twice <= -kneew) || (cfg.knee_db == 13'd0 && twice <= 26'sd0)) begin
						knee_q <= 1'b0;
						att_q  <= 25'sd0;
					end else if (cfg.knee_db != 13'd0 && twice <= kneew) begin
						// inside the knee, d lies in (0, 2k]
						knee_q <= 1'b1;
						num_q  <= 28'(dsum[14:0]) * 28'(dsum[14:0]);
					end else begin
						knee_q <= 1'b0;
						att_q  <= 25'((64'(cfg.slope) * 64'(o_db) + 64'sd16384) >>> 15);
					end
				end
				sskc_pkg::OP_KNEE_MUL: begin
					// magnitude of slope*d^2 plus half divisor
					neg_q  <= cfg.slope[15] && (num_q != 28'd0);
					quo_q  <= 64'(slope_mag) * 64'(num_q) + 64'({cfg.knee_db, 17'd0});
					den_q  <= {1'b0, cfg.knee_db, 18'd0};
					rem_q  <= 64'd0;
					divi_q <= 6'd0;
				end
				sskc_pkg::OP_DIV_STEP: begin
					// restoring division, one quotient bit per cycle
					if (!trial[64]) begin
						rem_q <= trial[63:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], quo_q[63]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
					divi_q <= divi_q + 6'd1;
					if (divi_q == 6'd63)
						att_q <= neg_q ? -25'({1'b0, quo_q[22:0], ~trial[64]})
							: 25'({1'b0, quo_q[22:0], ~trial[64]});
				end
				sskc_pkg::OP_SMOOTH: begin
					if (smoothr > 64'sd8388607)
						s_q <= 24'sd8388607;
					else if (smoothr < -64'sd8388608)
						s_q <= -24'sd8388608;
					else
						s_q <= 24'(smoothr);
				end
				sskc_pkg::OP_EXP: begin
					e_q    <= 24'(ep >>> 16);
					poly_q <= 18'd5118;
				end
				sskc_pkg::OP_POLY_STEP: begin
					case (cmd.sub)
						2'd0:    poly_q <= 18'd14815 + 18'(t64 >> 16);
						2'd1:    poly_q <= 18'd45602 + 18'(t64 >> 16);
						2'd2:    poly_q <= 18'(65536 + 18'(t64 >> 16));
						default: begin
							// shift by the integer part, round to Q4.12
							if (rr <= 8'sd0)
								lin_q <= 16'hFFFF;
							else if (rr > 8'sd40)
								lin_q <= 16'd0;
							else if ((({46'd0, poly_q} + (64'd1 << (rr - 8'sd1))) >> rr) > 64'd65535)
								lin_q <= 16'hFFFF;
							else
								lin_q <= 16'(({46'd0, poly_q} + (64'd1 << (rr - 8'sd1))) >> rr);
						end
					endcase
				end
				sskc_pkg::OP_APPLY_L, sskc_pkg::OP_APPLY_R: begin
					if (cmd.sub[1]) begin
						// second multiply: output gain and saturation
						if (cmd.sub[0])
							yr_q <= 24'(mulo);
						else
							yl_q <= 24'(mulo);
					end else if (cmd.op == sskc_pkg::OP_APPLY_L) begin
						if (cmd.sub[0])
							gr_q <= 41'(apl >>> 12);
						else
							gl_q <= 41'(apl >>> 12);
					end else begin
						// bypass: load raw sample as gained value
						if (cmd.sub[0])
							gr_q <= 41'(xr_q);
						else
							gl_q <= 41'(xl_q);
					end
				end
				default: ;
			endcase
		end
	end

	assign sts.knee_path = knee_q;
	assign sts.done_div  = (divi_q == 6'd63);
	assign res_l  = yl_q;
	assign res_r  = yr_q;
	assign res_gr = cfg.enable ? s_q : 24'sd0;

endmodule

// File: hdl/sskc_ctrl.sv
// sequencer that steps the datapath through one sample pair
module sskc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            enable,
	input  logic            in_fire,
	input  logic            out_free,
	input  sskc_pkg::sts_t  sts,
	output sskc_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done
);

	typedef enum logic [3:0] {
		S_IDLE, S_GAIN, S_LEVEL, S_LOG, S_DB, S_CURVE, S_KNEE, S_DIV,
		S_SMOOTH, S_EXP, S_POLY, S_APPLY, S_OUT, S_WAIT
	} state_t;

	state_t state_q;
	logic [3:0] cnt_q;
	logic en_q;

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= 4'd0;
			en_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) begin
					en_q    <= enable;
					cnt_q   <= 4'd0;
					state_q <= enable ? S_GAIN : S_APPLY;
				end
				S_GAIN: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd1) state_q <= S_LEVEL;
				end
				S_LEVEL: begin
					cnt_q   <= 4'd0;
					state_q <= S_LOG;
				end
				S_LOG: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= S_DB;
				end
				S_DB:    state_q <= S_CURVE;
				S_CURVE: state_q <= S_KNEE;
				S_KNEE:  state_q <= sts.knee_path ? S_DIV : S_SMOOTH;
				S_DIV:   if (sts.done_div) state_q <= S_SMOOTH;
				S_SMOOTH: state_q <= S_EXP;
				S_EXP: begin
					cnt_q   <= 4'd0;
					state_q <= S_POLY;
				end
				S_POLY: begin
					if (cnt_q == 4'd3) begin
						cnt_q   <= 4'd0;
						state_q <= S_APPLY;
					end else
						cnt_q <= cnt_q + 4'd1;
				end
				S_APPLY: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd3) state_q <= S_OUT;
				end
				S_OUT: state_q <= out_free ? S_IDLE : S_WAIT;
				S_WAIT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// decode of commands
	always_comb begin
		cmd.op  = sskc_pkg::OP_NONE;
		cmd.sub = cnt_q[1:0];
		case (state_q)
			S_IDLE:   if (in_fire) cmd.op = sskc_pkg::OP_LOAD;
			S_GAIN:   cmd.op = cnt_q[0] ? sskc_pkg::OP_GAIN_R : sskc_pkg::OP_GAIN_L;
			S_LEVEL:  cmd.op = sskc_pkg::OP_LEVEL;
			S_LOG:    cmd.op = sskc_pkg::OP_LOG_STEP;
			S_DB:     cmd.op = sskc_pkg::OP_DB;
			S_CURVE:  cmd.op = sskc_pkg::OP_CURVE;
			S_KNEE:   if (sts.knee_path) cmd.op = sskc_pkg::OP_KNEE_MUL;
			S_DIV:    cmd.op = sskc_pkg::OP_DIV_STEP;
			S_SMOOTH: cmd.op = sskc_pkg::OP_SMOOTH;
			S_EXP:    cmd.op = sskc_pkg::OP_EXP;
			S_POLY:   cmd.op = sskc_pkg::OP_POLY_STEP;
			// order: left first multiply, right first, left second, right second
			S_APPLY: begin
				cmd.op  = en_q ? sskc_pkg::OP_APPLY_L : sskc_pkg::OP_APPLY_R;
				cmd.sub = {cnt_q[1], cnt_q[0]};
			end
			default: cmd.op = sskc_pkg::OP_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	// result is ready from the output state until the output register takes it
	assign done = (state_q == S_OUT) || (state_q == S_WAIT);

endmodule

// File: hdl/stereo_soft_knee_compressor_unit.sv
// top level of the stereo soft-knee compressor
//  channel | direction | beat contents
//  s_axis  | in        | tdata: left_sample[23:0], right_sample[47:24]
//  m_axis  | out       | tdata: left_out, right_out, gain_reduction_db (72 bits)
//  apb     | in/out    | eight 32-bit settings registers at 4*i
// An enabled item runs every step, and on the soft-knee path also the bit-serial
// knee divider; a disabled item runs only the output steps. One item is in flight.
// The result sits in an output register, so a new item is taken while it waits.
// Reset is asynchronous and clears control and the smoothing state.
module stereo_soft_knee_compressor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // left_sample, right_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // left_out, right_out, gain_reduction_db
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sskc_pkg::cfg_t cfg;
	sskc_pkg::cmd_t cmd;
	sskc_pkg::sts_t sts;
	logic busy, done, in_fire, out_free;
	logic signed [23:0] res_l, res_r, res_gr;
	logic [71:0] out_q;
	logic out_v_q;

	assign pready = 1'b1;
	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid & s_axis_tready;
	assign out_free = !out_v_q || m_axis_tready;

	sskc_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	sskc_ctrl u_ctrl (
		.clk, .arst_n, .enable(cfg.enable), .in_fire, .out_free, .sts, .cmd, .busy, .done
	);

	sskc_datapath u_dp (
		.clk, .arst_n, .cfg, .cmd,
		.in_l(s_axis_tdata[23:0]), .in_r(s_axis_tdata[47:24]),
		.sts, .res_l, .res_r, .res_gr
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else begin
			if (done && out_free) begin
				out_v_q <= 1'b1;
				out_q   <= {res_gr, res_r, res_l};
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready) else $error("accept while busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done outside work");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
`endif

endmodule

// File: test/stereo_soft_knee_compressor_unit_tb.sv
// self-checking testbench for the stereo soft-knee compressor unit
module stereo_soft_knee_compressor_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumRegs    = 8;
	localparam int CycleLimit = 1000000;
	localparam int SettleWait = 150;

	// register indexes
	typedef enum int {
		REG_ENABLE, REG_IN_GAIN, REG_OUT_GAIN, REG_THRESHOLD,
		REG_SLOPE, REG_KNEE, REG_ATTACK, REG_RELEASE
	} reg_idx_t;

	// fields from the highest bits down
	typedef struct packed {
		logic [23:0] gain_reduction_db;
		logic [23:0] right_out;
		logic [23:0] left_out;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // left_sample, right_sample
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;        // left_out, right_out, gain_reduction_db
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic [47:0] pending_pairs[$];
	frame_t      expected_frames[$];
	logic [15:0] shadow_regs[NumRegs];
	longint      smooth_db;
	logic        in_fire = 1'b0;
	logic        hold_send = 1'b0;
	int          send_idle_pct = 38;
	int          recv_idle_pct = 64;
	int          error_count = 0;
	int          cycle_count = 0;

	stereo_soft_knee_compressor_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// clock, 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint sat_sample(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	// log2 of the level in Q.16, relative to full scale
	function automatic longint level_log2(longint m);
		int p;
		longint unsigned mant;
		longint fr;
		p = 0;
		fr = 0;
		while (p < 63 && (longint'(unsigned'(m)) >> (p + 1)) != 0) p++;
		mant = (p <= 30) ? (longint'(unsigned'(m)) << (30 - p)) : (longint'(unsigned'(m)) >> (p - 30));
		for (int i = 0; i < 16; i++) begin
			mant = (mant * mant) >> 30;
			fr = fr << 1;
			if (mant >= (64'd1 << 31)) begin
				mant = mant >> 1;
				fr = fr | 1;
			end
		end
		return longint'(p - 23) * 65536 + fr;
	endfunction

	// soft-knee static curve, attenuation in Q16.8 dB
	function automatic longint knee_curve(longint o, longint sl, longint k);
		longint twice, d, num, den, mag, q;
		twice = 2 * o;
		if (twice <= -k || (k == 0 && twice <= 0)) return 0;
		if (k > 0 && twice <= k) begin
			d = twice + k;
			num = sl * d * d;
			den = 8 * k * 32768;
			mag = (num < 0) ? -num : num;
			q = (mag + den / 2) / den;
			return (num < 0) ? -q : q;
		end
		return rnd_shift(sl * o, 15);
	endfunction

	// dB to linear Q4.12 gain via cubic 2^frac
	function automatic longint db_gain(longint s);
		longint e, n, f, p, r, v;
		e = rnd_shift(s * 64'sd2786635, 16);
		n = e >>> 16;
		f = e - n * 65536;
		p = 5118;
		p = 14815 + ((p * f) >>> 16);
		p = 45602 + ((p * f) >>> 16);
		p = 65536 + ((p * f) >>> 16);
		r = 4 - n;
		if (r <= 0) return 65535;
		if (r > 40) return 0;
		v = rnd_shift(p, int'(r));
		if (v < 0) return 0;
		if (v > 65535) return 65535;
		return v;
	endfunction

	// expected frame for one sample pair, advances the smoothing state
	function automatic frame_t compress_pair(logic [47:0] pair);
		frame_t fr;
		longint xl, xr, og, ig, gl, gr, al, ar, m, db, att, a, lin, yl, yr, red;
		xl = longint'($signed(pair[23:0]));
		xr = longint'($signed(pair[47:24]));
		og = longint'(shadow_regs[REG_OUT_GAIN]);
		red = 0;
		if (shadow_regs[REG_ENABLE][0]) begin
			ig = longint'(shadow_regs[REG_IN_GAIN]);
			gl = rnd_shift(xl * ig, 12);
			gr = rnd_shift(xr * ig, 12);
			al = (gl < 0) ? -gl : gl;
			ar = (gr < 0) ? -gr : gr;
			m = (al > ar) ? al : ar;
			if (m < 8) m = 8;
			db = rnd_shift(level_log2(m) * 64'sd394566, 24);
			att = knee_curve(db - longint'($signed(shadow_regs[REG_THRESHOLD][14:0])),
				longint'($signed(shadow_regs[REG_SLOPE])),
				longint'(shadow_regs[REG_KNEE][12:0]));
			a = (att < smooth_db) ? longint'(shadow_regs[REG_ATTACK])
				: longint'(shadow_regs[REG_RELEASE]);
			smooth_db = rnd_shift(a * smooth_db + (65536 - a) * att, 16);
			if (smooth_db > 64'sd8388607) smooth_db = 64'sd8388607;
			if (smooth_db < -64'sd8388608) smooth_db = -64'sd8388608;
			lin = db_gain(smooth_db);
			yl = sat_sample(rnd_shift(rnd_shift(gl * lin, 12) * og, 12));
			yr = sat_sample(rnd_shift(rnd_shift(gr * lin, 12) * og, 12));
			red = smooth_db;
		end else begin
			yl = sat_sample(rnd_shift(xl * og, 12));
			yr = sat_sample(rnd_shift(xr * og, 12));
		end
		fr.left_out = yl[23:0];
		fr.right_out = yr[23:0];
		fr.gain_reduction_db = red[23:0];
		return fr;
	endfunction

	// input driver, new beat only once the current one has gone
	always @(negedge clk) begin
		if (!s_axis_tvalid || in_fire) begin
			if (hold_send || pending_pairs.size() == 0 || $urandom_range(99) < send_idle_pct)
				s_axis_tvalid <= 1'b0;
			else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_pairs.pop_front();
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// input capture and prediction
	always @(posedge clk) begin
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			expected_frames.push_back(compress_pair(s_axis_tdata));
	end

	// result monitor
	always @(posedge clk) begin
		frame_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_frames.size() == 0) begin
				$error("result beat with nothing expected: %h", m_axis_tdata);
				error_count++;
			end else begin
				want = expected_frames.pop_front();
				if (got.left_out !== want.left_out) begin
					$error("left_out expected %0d got %0d",
						$signed(want.left_out), $signed(got.left_out));
					error_count++;
				end
				if (got.right_out !== want.right_out) begin
					$error("right_out expected %0d got %0d",
						$signed(want.right_out), $signed(got.right_out));
					error_count++;
				end
				if (got.gain_reduction_db !== want.gain_reduction_db) begin
					$error("gain_reduction_db expected %0d got %0d",
						$signed(want.gain_reduction_db), $signed(got.gain_reduction_db));
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= {16'h0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ENABLE:    shadow_regs[idx] = val & 16'h0001;
			REG_THRESHOLD: shadow_regs[idx] = val & 16'h7fff;
			REG_KNEE:      shadow_regs[idx] = val & 16'h1fff;
			default:       shadow_regs[idx] = val;
		endcase
	endtask

	// let everything queued come out, then allow the block to settle
	task automatic drain();
		wait (pending_pairs.size() == 0 && !s_axis_tvalid && expected_frames.size() == 0);
		repeat (SettleWait) @(negedge clk);
	endtask

	task automatic load_setting(logic en, logic [15:0] ig, logic [15:0] og, int thr,
		int sl, int knee, logic [15:0] att, logic [15:0] rel);
		drain();
		reg_write(REG_ENABLE, {15'h0, en});
		reg_write(REG_IN_GAIN, ig);
		reg_write(REG_OUT_GAIN, og);
		reg_write(REG_THRESHOLD, 16'(thr));
		reg_write(REG_SLOPE, 16'(sl));
		reg_write(REG_KNEE, 16'(knee));
		reg_write(REG_ATTACK, att);
		reg_write(REG_RELEASE, rel);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(40)) - 20);
			2: return $urandom_range(1) ? 24'h7fffff - 24'($urandom_range(4095))
				: 24'h800000 + 24'($urandom_range(4095));
			default: return 24'($signed(24'($urandom)) >>> $urandom_range(16));
		endcase
	endfunction

	function automatic logic [15:0] rand_gain();
		case ($urandom_range(4))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'd4096;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_alpha();
		case ($urandom_range(4))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom_range(65535, 50000));
		endcase
	endfunction

	initial begin
		for (int i = 0; i < NumRegs; i++) shadow_regs[i] = '0;
		shadow_regs[REG_IN_GAIN] = 16'd4096;
		shadow_regs[REG_OUT_GAIN] = 16'd4096;
		shadow_regs[REG_THRESHOLD] = 16'h6c00;
		shadow_regs[REG_SLOPE] = 16'hc000;
		shadow_regs[REG_ATTACK] = 16'd65000;
		shadow_regs[REG_RELEASE] = 16'd65500;
		smooth_db = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset settings (bypass), extremes of the samples
		pending_pairs.push_back({24'h7fffff, 24'h800000});
		pending_pairs.push_back({24'h000000, 24'h000000});
		pending_pairs.push_back({24'h800000, 24'h7fffff});
		pending_pairs.push_back({24'hffffff, 24'h000001});
		// bypass with full output gain saturates
		load_setting(1'b0, 16'd4096, 16'hffff, -5120, -16384, 0, 16'd65000, 16'd65500);
		pending_pairs.push_back({24'h7fffff, 24'h800000});
		pending_pairs.push_back({24'h001000, 24'hfff000});
		// hard knee, level below the floor and loud
		load_setting(1'b1, 16'd4096, 16'd4096, -5120, -16384, 0, 16'd65000, 16'd65500);
		pending_pairs.push_back({24'h000000, 24'h000000});
		pending_pairs.push_back({24'h000003, 24'hfffffd});
		pending_pairs.push_back({24'h7fffff, 24'h800000});
		pending_pairs.push_back({24'h400000, 24'h000000});
		// 24 dB soft knee, instant attack and release
		load_setting(1'b1, 16'hffff, 16'd4096, -15360, -32768, 6144, 16'h0000, 16'h0000);
		pending_pairs.push_back({24'h7fffff, 24'h7fffff});
		pending_pairs.push_back({24'h000100, 24'h000000});
		pending_pairs.push_back({24'h000000, 24'h800000});
		pending_pairs.push_back({24'h000010, 24'h000020});
		// positive slope expands, gain saturates; zero threshold
		load_setting(1'b1, 16'd4096, 16'hffff, 0, 32767, 512, 16'hffff, 16'h0000);
		pending_pairs.push_back({24'h7fffff, 24'h800000});
		pending_pairs.push_back({24'h100000, 24'h010000});
		pending_pairs.push_back({24'h7fffff, 24'h7fffff});
		// zero input gain, slowest smoothing
		load_setting(1'b1, 16'h0000, 16'h0000, -15360, 0, 0, 16'hffff, 16'hffff);
		pending_pairs.push_back({24'h7fffff, 24'h800000});
		pending_pairs.push_back({24'h123456, 24'h654321});

		// random settings, idling pattern changes every three settings
		for (int set = 0; set < 9; set++) begin
			drain();
			if (set == 3) begin
				send_idle_pct = 64;
				recv_idle_pct = 38;
			end else if (set == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			load_setting(($urandom_range(4) != 0), rand_gain(), rand_gain(),
				-$urandom_range(15360), ($urandom_range(9) == 0) ? $urandom_range(32767)
				: -$urandom_range(32768),
				($urandom_range(2) == 0) ? 0 : $urandom_range(6144),
				rand_alpha(), rand_alpha());
			for (int n = 0; n < 100; n++) begin
				pending_pairs.push_back({rand_sample(), rand_sample()});
				// hold off the sender with beats pending until every result is back
				if (set == 4 && n == 50) begin
					wait (pending_pairs.size() <= 25);
					hold_send = 1'b1;
					wait (expected_frames.size() == 0 && !s_axis_tvalid);
					repeat (10) @(negedge clk);
					hold_send = 1'b0;
				end
			end
		end

		drain();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: sim.f
hdl/sskc_pkg.sv
hdl/sskc_regs.sv
hdl/sskc_datapath.sv
hdl/sskc_ctrl.sv
hdl/stereo_soft_knee_compressor_unit.sv
test/stereo_soft_knee_compressor_unit_tb.sv
